// ===== hw/rtl/wavhp_pkg.sv =====
// Package for the RIFF/WAVE PCM header parser and sample unpacker.
// Holds mode, kind and error codes, chunk tags, parse phases and the result word type.
// No dependencies.
package wavhp_pkg;

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_HEADER  = 2'd1;
    localparam logic [1:0] MODE_DATA    = 2'd2;

    localparam logic [1:0] KIND_HDR_OK   = 2'd0;
    localparam logic [1:0] KIND_HDR_BAD  = 2'd1;
    localparam logic [1:0] KIND_SAMPLE   = 2'd2;
    localparam logic [1:0] KIND_REFUSED  = 2'd3;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_NOT_RIFF   = 4'd1;
    localparam logic [3:0] ERR_RIFF_SMALL = 4'd2;
    localparam logic [3:0] ERR_NOT_WAVE   = 4'd3;
    localparam logic [3:0] ERR_OVERRUN    = 4'd4;
    localparam logic [3:0] ERR_FMT_SIZE   = 4'd5;
    localparam logic [3:0] ERR_NOT_PCM    = 4'd6;
    localparam logic [3:0] ERR_CHANNELS   = 4'd7;
    localparam logic [3:0] ERR_BITS       = 4'd8;
    localparam logic [3:0] ERR_ALIGN      = 4'd9;
    localparam logic [3:0] ERR_RATE       = 4'd10;
    localparam logic [3:0] ERR_MISSING    = 4'd11;
    localparam logic [3:0] ERR_EOS        = 4'd12;

    // little-endian tags as they sit in the shift register
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] PCM_FORMAT = 16'h0001;
    localparam logic [31:0] FMT_SIZE   = 32'd16;
    localparam logic [7:0]  SIGN_FLIP  = 8'h80;

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_WAVE = 3'd1;
    localparam logic [2:0] PH_CHDR = 3'd2;
    localparam logic [2:0] PH_FMT  = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  error_code;
        logic [1:0]  channel_count;
        logic [4:0]  bits_per_sample;
        logic [31:0] sample_rate;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
        logic [7:0]  out_byte;
        logic        frame_end;
    } result_t;

endpackage

// ===== hw/rtl/wavhp_parser.sv =====
// Parser core: all header and data-phase state, one word processed per fire strobe.
// Produces at most one result word per processed word. Depends on wavhp_pkg.
module wavhp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [1:0]        in_mode,
    input  logic [7:0]        in_byte,
    input  logic              in_eos,
    output logic              res_valid,
    output wavhp_pkg::result_t res
);
    import wavhp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  fidx_reg, fidx_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] riff_left_reg, riff_left_next;
    logic [31:0] chunk_left_reg, chunk_left_next;
    logic [31:0] file_pos_reg, file_pos_next;
    logic [1:0]  chan_reg, chan_next;
    logic [4:0]  depth_reg, depth_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] byte_rate_reg, byte_rate_next;
    logic [15:0] align_reg, align_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] size_reg, size_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [31:0] data_pos_reg, data_pos_next;
    logic [1:0]  frame_idx_reg, frame_idx_next;
    logic [31:0] prod_reg;

    logic [15:0] hi;
    logic [31:0] rl_sub8, rl_sub_size, cl_dec;
    logic        is_data;
    logic        nc_req;
    logic [31:0] nc_rl;
    logic        fin;
    logic [3:0]  fin_err;
    logic [3:0]  frame;
    logic [2:0]  fidx_inc;
    logic [33:0] end_pos;
    logic [4:0]  align_want;

    assign hi          = shift_next[31:16];
    assign rl_sub8     = riff_left_reg - 32'd8;
    assign rl_sub_size = rl_sub8 - shift_next;
    assign cl_dec      = chunk_left_reg - 32'd1;
    assign is_data     = (chunk_left_reg == TAG_DATA);
    assign frame       = {2'b00, chan_reg} * {2'b00, depth_reg[4:3]};
    assign fidx_inc    = {1'b0, frame_idx_reg} + 3'd1;
    assign end_pos     = {2'b00, data_pos_reg} + {30'd0, frame} - {32'd0, frame_idx_reg};
    assign align_want  = {3'b000, chan_reg} * {3'b000, hi[4:3]};

    always_comb begin
        phase_next      = phase_reg;
        fidx_next       = fidx_reg;
        shift_next      = {in_byte, shift_reg[31:8]};
        riff_left_next  = riff_left_reg;
        chunk_left_next = chunk_left_reg;
        file_pos_next   = file_pos_reg;
        chan_next       = chan_reg;
        depth_next      = depth_reg;
        rate_next       = rate_reg;
        byte_rate_next  = byte_rate_reg;
        align_next      = align_reg;
        offset_next     = offset_reg;
        size_next       = size_reg;
        fmt_seen_next   = fmt_seen_reg;
        data_seen_next  = data_seen_reg;
        hdr_ok_next     = hdr_ok_reg;
        data_pos_next   = data_pos_reg;
        frame_idx_next  = frame_idx_reg;
        nc_req          = 1'b0;
        nc_rl           = riff_left_reg;
        fin             = 1'b0;
        fin_err         = ERR_NONE;
        res_valid       = 1'b0;
        res             = '0;

        case (in_mode)
            MODE_RESTART: begin
                phase_next      = PH_RIFF;
                fidx_next       = '0;
                shift_next      = '0;
                riff_left_next  = '0;
                chunk_left_next = '0;
                file_pos_next   = '0;
                chan_next       = '0;
                depth_next      = '0;
                rate_next       = '0;
                byte_rate_next  = '0;
                align_next      = '0;
                offset_next     = '0;
                size_next       = '0;
                fmt_seen_next   = 1'b0;
                data_seen_next  = 1'b0;
                hdr_ok_next     = 1'b0;
                data_pos_next   = '0;
                frame_idx_next  = '0;
            end
            MODE_DATA: begin
                shift_next = shift_reg;
                res_valid  = 1'b1;
                if (!hdr_ok_reg || frame == 4'd0 || data_pos_reg < {30'd0, frame_idx_reg}
                        || end_pos > {2'b00, size_reg}) begin
                    res.kind = KIND_REFUSED;
                end else begin
                    res.kind      = KIND_SAMPLE;
                    res.out_byte  = (depth_reg == 5'd8) ? (in_byte ^ SIGN_FLIP) : in_byte;
                    data_pos_next = data_pos_reg + 32'd1;
                    if ({1'b0, fidx_inc} >= frame) begin
                        frame_idx_next = '0;
                        res.frame_end  = 1'b1;
                    end else begin
                        frame_idx_next = fidx_inc[1:0];
                    end
                end
            end
            MODE_HEADER: begin
                if (phase_reg == PH_DONE) begin
                    shift_next = shift_reg;
                end else begin
                    file_pos_next = file_pos_reg + 32'd1;
                    fidx_next     = fidx_reg + 5'd1;
                    case (phase_reg)
                        PH_RIFF: begin
                            if (fidx_reg == 5'd3)
                                chunk_left_next = shift_next;
                            if (fidx_reg == 5'd7) begin
                                if (chunk_left_reg != TAG_RIFF) begin
                                    fin = 1'b1;
                                    fin_err = ERR_NOT_RIFF;
                                end else if (shift_next < 32'd4) begin
                                    fin = 1'b1;
                                    fin_err = ERR_RIFF_SMALL;
                                end else begin
                                    riff_left_next = shift_next - 32'd4;
                                    phase_next     = PH_WAVE;
                                    fidx_next      = '0;
                                end
                            end
                        end
                        PH_WAVE: begin
                            if (fidx_reg == 5'd3) begin
                                if (shift_next != TAG_WAVE) begin
                                    fin = 1'b1;
                                    fin_err = ERR_NOT_WAVE;
                                end else begin
                                    nc_req = 1'b1;
                                end
                            end
                        end
                        PH_CHDR: begin
                            if (fidx_reg == 5'd3)
                                chunk_left_next = shift_next;
                            if (fidx_reg == 5'd7) begin
                                riff_left_next = rl_sub8;
                                if (rl_sub8 < shift_next) begin
                                    fin = 1'b1;
                                    fin_err = ERR_OVERRUN;
                                end else if (chunk_left_reg == TAG_FMT) begin
                                    if (shift_next != FMT_SIZE) begin
                                        fin = 1'b1;
                                        fin_err = ERR_FMT_SIZE;
                                    end else begin
                                        phase_next = PH_FMT;
                                        fidx_next  = '0;
                                    end
                                end else begin
                                    if (is_data) begin
                                        offset_next    = file_pos_next;
                                        size_next      = shift_next;
                                        data_seen_next = 1'b1;
                                    end
                                    riff_left_next = rl_sub_size;
                                    if ((is_data && fmt_seen_reg) || shift_next == 32'd0) begin
                                        nc_req = 1'b1;
                                        nc_rl  = rl_sub_size;
                                    end else begin
                                        chunk_left_next = shift_next;
                                        phase_next      = PH_SKIP;
                                    end
                                end
                            end
                        end
                        PH_FMT: begin
                            if (fidx_reg == 5'd1 && hi != PCM_FORMAT) begin
                                fin = 1'b1;
                                fin_err = ERR_NOT_PCM;
                            end
                            if (fidx_reg == 5'd3) begin
                                if (hi != 16'd1 && hi != 16'd2) begin
                                    fin = 1'b1;
                                    fin_err = ERR_CHANNELS;
                                end else begin
                                    chan_next = hi[1:0];
                                end
                            end
                            if (fidx_reg == 5'd7)
                                rate_next = shift_next;
                            if (fidx_reg == 5'd11)
                                byte_rate_next = shift_next;
                            if (fidx_reg == 5'd13)
                                align_next = hi;
                            if (fidx_reg == 5'd15) begin
                                if (hi != 16'd8 && hi != 16'd16) begin
                                    fin = 1'b1;
                                    fin_err = ERR_BITS;
                                end else begin
                                    depth_next = hi[4:0];
                                    if (align_reg != {11'd0, align_want}) begin
                                        fin = 1'b1;
                                        fin_err = ERR_ALIGN;
                                    end else if (byte_rate_reg != prod_reg) begin
                                        fin = 1'b1;
                                        fin_err = ERR_RATE;
                                    end else begin
                                        fmt_seen_next  = 1'b1;
                                        riff_left_next = riff_left_reg - FMT_SIZE;
                                        nc_req         = 1'b1;
                                        nc_rl          = riff_left_reg - FMT_SIZE;
                                    end
                                end
                            end
                        end
                        PH_SKIP: begin
                            chunk_left_next = cl_dec;
                            if (cl_dec == 32'd0)
                                nc_req = 1'b1;
                        end
                        default: begin
                        end
                    endcase

                    // walk to the next chunk header or finish
                    if (nc_req) begin
                        if (fmt_seen_next && data_seen_next) begin
                            fin = 1'b1;
                            fin_err = ERR_NONE;
                        end else if (nc_rl == 32'd0) begin
                            fin = 1'b1;
                            fin_err = ERR_MISSING;
                        end else if (nc_rl < 32'd8) begin
                            fin = 1'b1;
                            fin_err = ERR_OVERRUN;
                        end else begin
                            phase_next = PH_CHDR;
                            fidx_next  = '0;
                        end
                    end

                    if (!fin && in_eos) begin
                        fin = 1'b1;
                        fin_err = ERR_EOS;
                    end

                    if (fin) begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        if (fin_err == ERR_NONE) begin
                            hdr_ok_next         = 1'b1;
                            data_pos_next       = '0;
                            frame_idx_next      = '0;
                            res.kind            = KIND_HDR_OK;
                            res.channel_count   = chan_next;
                            res.bits_per_sample = depth_next;
                            res.sample_rate     = rate_next;
                            res.payload_offset  = offset_next;
                            res.payload_size    = size_next;
                        end else begin
                            res.kind       = KIND_HDR_BAD;
                            res.error_code = fin_err;
                        end
                    end
                end
            end
            default: begin
                shift_next = shift_reg;
            end
        endcase
    end

    // align * rate, registered; both operands settle well before fmt byte 15
    always_ff @(posedge aclk) begin
        prod_reg <= 32'({16'd0, align_reg} * rate_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_RIFF;
            fidx_reg       <= '0;
            shift_reg      <= '0;
            riff_left_reg  <= '0;
            chunk_left_reg <= '0;
            file_pos_reg   <= '0;
            chan_reg       <= '0;
            depth_reg      <= '0;
            rate_reg       <= '0;
            byte_rate_reg  <= '0;
            align_reg      <= '0;
            offset_reg     <= '0;
            size_reg       <= '0;
            fmt_seen_reg   <= 1'b0;
            data_seen_reg  <= 1'b0;
            hdr_ok_reg     <= 1'b0;
            data_pos_reg   <= '0;
            frame_idx_reg  <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            fidx_reg       <= fidx_next;
            shift_reg      <= shift_next;
            riff_left_reg  <= riff_left_next;
            chunk_left_reg <= chunk_left_next;
            file_pos_reg   <= file_pos_next;
            chan_reg       <= chan_next;
            depth_reg      <= depth_next;
            rate_reg       <= rate_next;
            byte_rate_reg  <= byte_rate_next;
            align_reg      <= align_next;
            offset_reg     <= offset_next;
            size_reg       <= size_next;
            fmt_seen_reg   <= fmt_seen_next;
            data_seen_reg  <= data_seen_next;
            hdr_ok_reg     <= hdr_ok_next;
            data_pos_reg   <= data_pos_next;
            frame_idx_reg  <= frame_idx_next;
        end
    end

endmodule

// ===== hw/rtl/wavhp_out_stage.sv =====
// Result register: holds one result word until the downstream side takes it.
// Depends on wavhp_pkg.
module wavhp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  wavhp_pkg::result_t load_word,
    input  logic               m_ready,
    output logic               m_valid,
    output logic               free,
    output wavhp_pkg::result_t word
);
    import wavhp_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign word    = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            word_reg <= load_word;
        end
    end

endmodule

// ===== hw/rtl/wav_header_parser_sample_unpack.sv =====
// WAV header parser and sample byte unpacker, top level.
// An accepted word sits in the input register; its result word then goes to the result register.
// Throughput: one input word per cycle; the input register advances whenever the
// word produces no result or the result register is free.
// Reset: synchronous active-low aresetn clears the parser to "expect RIFF"; mode 0 does the same.
// Depends on wavhp_pkg, wavhp_parser, wavhp_out_stage.
module wav_header_parser_sample_unpack (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_error_code,
    output logic [1:0]  m_channel_count,
    output logic [4:0]  m_bits_per_sample,
    output logic [31:0] m_sample_rate,
    output logic [31:0] m_payload_offset,
    output logic [31:0] m_payload_size,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end
);
    import wavhp_pkg::*;

    logic       in_valid_reg;
    logic [1:0] mode_reg;
    logic [7:0] byte_reg;
    logic       eos_reg;
    logic       res_valid;
    result_t    res;
    result_t    out_word;
    logic       out_free;
    logic       advance;

    assign advance = in_valid_reg && (!res_valid || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mode_reg <= s_mode;
            byte_reg <= s_in_byte;
            eos_reg  <= s_end_of_stream;
        end
    end

    wavhp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .in_mode   (mode_reg),
        .in_byte   (byte_reg),
        .in_eos    (eos_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wavhp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_word (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .free      (out_free),
        .word      (out_word)
    );

    assign m_kind            = out_word.kind;
    assign m_error_code      = out_word.error_code;
    assign m_channel_count   = out_word.channel_count;
    assign m_bits_per_sample = out_word.bits_per_sample;
    assign m_sample_rate     = out_word.sample_rate;
    assign m_payload_offset  = out_word.payload_offset;
    assign m_payload_size    = out_word.payload_size;
    assign m_out_byte        = out_word.out_byte;
    assign m_frame_end       = out_word.frame_end;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for wav_header_parser_sample_unpack: WAV byte streams in header and
// data mode; each result word checked against the in-bench parser model or a directed row.
// Depends on wavhp_pkg and the RTL of the block.
module testbench;
    import wavhp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         WORD_TARGET = 1300;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       eos;
        logic       fixed;
        logic [1:0] kind;
        logic [3:0] code;
    } table_row_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       eos;
        logic       fixed;
        result_t    want;
    } stim_word_t;

    typedef enum logic [1:0] {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_COIN} ready_style_t;

    localparam table_row_t DIRECTED_ROWS [25] = '{
        '{MODE_UNUSED,  8'hFF, 1'b1, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_DATA,    8'h00, 1'b0, 1'b1, KIND_REFUSED, ERR_NONE},
        '{MODE_DATA,    8'hFF, 1'b1, 1'b1, KIND_REFUSED, ERR_NONE},
        '{MODE_HEADER,  8'h52, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h49, 1'b1, 1'b1, KIND_HDR_BAD, ERR_EOS},
        '{MODE_HEADER,  8'h46, 1'b1, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_RESTART, 8'h00, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h52, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h49, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h46, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h58, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'hFF, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'hFF, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'hFF, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'hFF, 1'b0, 1'b1, KIND_HDR_BAD, ERR_NOT_RIFF},
        '{MODE_RESTART, 8'h00, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h52, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h49, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h46, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h46, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h03, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h00, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h00, 1'b0, 1'b0, KIND_HDR_OK,  ERR_NONE},
        '{MODE_HEADER,  8'h00, 1'b0, 1'b1, KIND_HDR_BAD, ERR_RIFF_SMALL},
        '{MODE_RESTART, 8'hFF, 1'b1, 1'b0, KIND_HDR_OK,  ERR_NONE}
    };

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = MODE_RESTART;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_end_of_stream = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [3:0]  m_error_code;
    logic [1:0]  m_channel_count;
    logic [4:0]  m_bits_per_sample;
    logic [31:0] m_sample_rate;
    logic [31:0] m_payload_offset;
    logic [31:0] m_payload_size;
    logic [7:0]  m_out_byte;
    logic        m_frame_end;

    wav_header_parser_sample_unpack i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_in_byte         (s_in_byte),
        .s_end_of_stream   (s_end_of_stream),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_error_code      (m_error_code),
        .m_channel_count   (m_channel_count),
        .m_bits_per_sample (m_bits_per_sample),
        .m_sample_rate     (m_sample_rate),
        .m_payload_offset  (m_payload_offset),
        .m_payload_size    (m_payload_size),
        .m_out_byte        (m_out_byte),
        .m_frame_end       (m_frame_end)
    );

    stim_word_t   pending_words[$];
    result_t      expected_words[$];
    logic [7:0]   file_bytes[$];
    stim_word_t   cur_word;
    int           words_fed = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           stim_done = 1'b0;
    int unsigned  burst_left = 0;
    int unsigned  gap_left = 0;
    ready_style_t ready_style = READY_ALWAYS;
    int unsigned  ready_span = 0;
    int unsigned  ready_tick = 0;

    // parser model state
    logic [2:0]  hp_phase;
    logic [4:0]  hp_idx;
    logic [31:0] hp_shift;
    logic [31:0] hp_riff_left;
    logic [31:0] hp_chunk_left;
    logic [31:0] hp_pos;
    logic [1:0]  st_channels;
    logic [4:0]  st_depth;
    logic [31:0] st_rate;
    logic [31:0] st_byte_rate;
    logic [15:0] st_align;
    logic [31:0] st_offset;
    logic [31:0] st_size;
    logic        seen_fmt;
    logic        seen_data;
    logic        hdr_accepted;
    logic [31:0] dp_pos;
    logic [1:0]  dp_frame_idx;
    result_t     pred_word;

    function automatic void parser_clear();
        hp_phase      = PH_RIFF;
        hp_idx        = '0;
        hp_shift      = '0;
        hp_riff_left  = '0;
        hp_chunk_left = '0;
        hp_pos        = '0;
        st_channels   = '0;
        st_depth      = '0;
        st_rate       = '0;
        st_byte_rate  = '0;
        st_align      = '0;
        st_offset     = '0;
        st_size       = '0;
        seen_fmt      = 1'b0;
        seen_data     = 1'b0;
        hdr_accepted  = 1'b0;
        dp_pos        = '0;
        dp_frame_idx  = '0;
    endfunction

    function automatic bit header_verdict(input logic [3:0] err);
        pred_word = '0;
        hp_phase = PH_DONE;
        if (err == ERR_NONE) begin
            hdr_accepted = 1'b1;
            dp_pos = '0;
            dp_frame_idx = '0;
            pred_word.kind = KIND_HDR_OK;
            pred_word.channel_count = st_channels;
            pred_word.bits_per_sample = st_depth;
            pred_word.sample_rate = st_rate;
            pred_word.payload_offset = st_offset;
            pred_word.payload_size = st_size;
        end else begin
            pred_word.kind = KIND_HDR_BAD;
            pred_word.error_code = err;
        end
        return 1'b1;
    endfunction

    function automatic bit chunk_boundary();
        if (seen_fmt && seen_data) return header_verdict(ERR_NONE);
        if (hp_riff_left == 32'd0) return header_verdict(ERR_MISSING);
        if (hp_riff_left < 32'd8) return header_verdict(ERR_OVERRUN);
        hp_phase = PH_CHDR;
        hp_idx = '0;
        return 1'b0;
    endfunction

    function automatic bit chunk_header_end();
        logic [31:0] tag;
        logic [31:0] size;
        tag = hp_chunk_left;
        size = hp_shift;
        hp_riff_left = hp_riff_left - 32'd8;
        if (hp_riff_left < size) return header_verdict(ERR_OVERRUN);
        if (tag == TAG_FMT) begin
            if (size != FMT_SIZE) return header_verdict(ERR_FMT_SIZE);
            hp_phase = PH_FMT;
            hp_idx = '0;
            return 1'b0;
        end
        if (tag == TAG_DATA) begin
            st_offset = hp_pos;
            st_size = size;
            seen_data = 1'b1;
        end
        hp_riff_left = hp_riff_left - size;
        if ((tag == TAG_DATA && seen_fmt) || size == 32'd0) return chunk_boundary();
        hp_chunk_left = size;
        hp_phase = PH_SKIP;
        return 1'b0;
    endfunction

    function automatic bit fmt_field_byte();
        logic [4:0]  idx;
        logic [31:0] hi;
        logic [31:0] frame_bytes;
        logic [31:0] rate_prod;
        idx = hp_idx;
        hi = hp_shift >> 16;
        hp_idx = idx + 5'd1;
        if (idx == 5'd1 && hi != {16'h0, PCM_FORMAT}) return header_verdict(ERR_NOT_PCM);
        if (idx == 5'd3) begin
            if (hi != 32'd1 && hi != 32'd2) return header_verdict(ERR_CHANNELS);
            st_channels = hi[1:0];
        end
        if (idx == 5'd7) st_rate = hp_shift;
        if (idx == 5'd11) st_byte_rate = hp_shift;
        if (idx == 5'd13) st_align = hi[15:0];
        if (idx == 5'd15) begin
            if (hi != 32'd8 && hi != 32'd16) return header_verdict(ERR_BITS);
            st_depth = hi[4:0];
            frame_bytes = {30'h0, st_channels} * (hi / 32'd8);
            if ({16'h0, st_align} != frame_bytes) return header_verdict(ERR_ALIGN);
            rate_prod = {16'h0, st_align} * st_rate;
            if (st_byte_rate != rate_prod) return header_verdict(ERR_RATE);
            seen_fmt = 1'b1;
            hp_riff_left = hp_riff_left - FMT_SIZE;
            return chunk_boundary();
        end
        return 1'b0;
    endfunction

    function automatic bit parse_header_byte(input logic [7:0] b);
        logic [4:0] idx;
        bit         got;
        idx = hp_idx;
        got = 1'b0;
        hp_pos = hp_pos + 32'd1;
        hp_shift = {b, hp_shift[31:8]};
        case (hp_phase)
            PH_RIFF: begin
                hp_idx = idx + 5'd1;
                if (idx == 5'd3) hp_chunk_left = hp_shift;
                if (idx == 5'd7) begin
                    if (hp_chunk_left != TAG_RIFF) got = header_verdict(ERR_NOT_RIFF);
                    else if (hp_shift < 32'd4) got = header_verdict(ERR_RIFF_SMALL);
                    else begin
                        hp_riff_left = hp_shift - 32'd4;
                        hp_phase = PH_WAVE;
                        hp_idx = '0;
                    end
                end
            end
            PH_WAVE: begin
                hp_idx = idx + 5'd1;
                if (idx == 5'd3) begin
                    if (hp_shift != TAG_WAVE) got = header_verdict(ERR_NOT_WAVE);
                    else got = chunk_boundary();
                end
            end
            PH_CHDR: begin
                hp_idx = idx + 5'd1;
                if (idx == 5'd3) hp_chunk_left = hp_shift;
                if (idx == 5'd7) got = chunk_header_end();
            end
            PH_FMT: got = fmt_field_byte();
            PH_SKIP: begin
                hp_chunk_left = hp_chunk_left - 32'd1;
                if (hp_chunk_left == 32'd0) got = chunk_boundary();
            end
            default: got = 1'b0;
        endcase
        return got;
    endfunction

    function automatic bit sample_byte(input logic [7:0] b);
        logic [31:0] frame_bytes;
        logic [31:0] next_idx;
        logic [63:0] frame_start;
        pred_word = '0;
        frame_bytes = {30'h0, st_channels} * ({27'h0, st_depth} / 32'd8);
        frame_start = {32'h0, dp_pos} - {62'h0, dp_frame_idx};
        if (!hdr_accepted || frame_bytes == 32'd0 ||
            frame_start + {32'h0, frame_bytes} > {32'h0, st_size}) begin
            pred_word.kind = KIND_REFUSED;
            return 1'b1;
        end
        pred_word.kind = KIND_SAMPLE;
        pred_word.out_byte = (st_depth == 5'd8) ? (b ^ SIGN_FLIP) : b;
        dp_pos = dp_pos + 32'd1;
        next_idx = {30'h0, dp_frame_idx} + 32'd1;
        if (next_idx >= frame_bytes) begin
            dp_frame_idx = '0;
            pred_word.frame_end = 1'b1;
        end else begin
            dp_frame_idx = next_idx[1:0];
        end
        return 1'b1;
    endfunction

    function automatic bit predict_word(input logic [1:0] mode, input logic [7:0] b,
                                        input logic eos);
        bit got;
        pred_word = '0;
        got = 1'b0;
        case (mode)
            MODE_RESTART: parser_clear();
            MODE_DATA: got = sample_byte(b);
            MODE_HEADER: begin
                if (hp_phase != PH_DONE) begin
                    got = parse_header_byte(b);
                    if (!got && eos) got = header_verdict(ERR_EOS);
                end
            end
            default: got = 1'b0;
        endcase
        return got;
    endfunction

    function automatic void queue_word(input logic [1:0] mode, input logic [7:0] data,
                                       input logic eos);
        stim_word_t w;
        w = '0;
        w.mode = mode;
        w.data = data;
        w.eos = eos;
        pending_words.push_back(w);
    endfunction

    function automatic void push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) file_bytes.push_back(v[8*k +: 8]);
    endfunction

    function automatic void push_fmt(input logic [31:0] size, input logic [15:0] code,
                                     input logic [15:0] ch, input logic [31:0] rate,
                                     input logic [31:0] brate, input logic [15:0] align,
                                     input logic [15:0] bits);
        push_le(TAG_FMT, 4);
        push_le(size, 4);
        push_le({16'h0, code}, 2);
        push_le({16'h0, ch}, 2);
        push_le(rate, 4);
        push_le(brate, 4);
        push_le({16'h0, align}, 2);
        push_le({16'h0, bits}, 2);
    endfunction

    function automatic void push_other_chunk();
        logic [31:0] tag;
        logic [31:0] csize;
        tag = $urandom;
        if (tag == TAG_FMT || tag == TAG_DATA) tag = tag ^ 32'd1;
        csize = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 6);
        push_le(tag, 4);
        push_le(csize, 4);
        for (int k = 0; k < csize && k < 8; k++)
            file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // one WAV file, mostly well formed, then its data words and usually a restart
    task automatic build_wav_file();
        logic [15:0] ch;
        logic [15:0] bits;
        logic [15:0] align;
        logic [15:0] fmt_code;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [31:0] prod;
        logic [31:0] fmt_size;
        logic [31:0] dsize;
        logic [31:0] riff_size;
        logic [7:0]  tail[$];
        int unsigned n_other;
        int unsigned cut;
        int unsigned feed;
        bit          fmt_present;
        bit          data_present;
        bit          payload_inline;
        bit          eos_last;
        file_bytes.delete();
        fmt_present = 1'b0;
        data_present = 1'b0;
        payload_inline = 1'b0;
        dsize = '0;

        if ($urandom_range(0, 99) < 92) ch = 16'($urandom_range(1, 2));
        else case ($urandom_range(0, 2))
            0: ch = 16'd0;
            1: ch = 16'd3;
            default: ch = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 99) < 92) bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
        else case ($urandom_range(0, 2))
            0: bits = 16'd24;
            1: bits = 16'd4;
            default: bits = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0: rate = 32'hFFFF_FFFF;
            1: rate = 32'h0;
            2, 3, 4, 5: rate = $urandom_range(8000, 192000);
            default: rate = $urandom;
        endcase
        prod = {16'h0, ch} * ({16'h0, bits} / 32'd8);
        align = ($urandom_range(0, 99) < 92) ? prod[15:0] : 16'($urandom_range(0, 65535));
        brate = ($urandom_range(0, 99) < 92) ? {16'h0, align} * rate : $urandom;
        fmt_code = ($urandom_range(0, 99) < 95) ? PCM_FORMAT : 16'($urandom_range(0, 65535));
        fmt_size = ($urandom_range(0, 99) < 95) ? FMT_SIZE : $urandom_range(0, 40);

        n_other = $urandom_range(0, 2);
        for (int k = 0; k < n_other; k++) push_other_chunk();
        if ($urandom_range(0, 99) < 15) begin
            feed = $urandom_range(0, 6);
            push_le(TAG_DATA, 4);
            push_le(feed, 4);
            for (int k = 0; k < feed; k++) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 10) begin
            prod = $urandom_range(1, 2);
            feed = $urandom_range(0, 1) ? 16 : 8;
            prod = prod * (feed / 8);
            push_fmt(FMT_SIZE, PCM_FORMAT, 16'(prod / (feed / 8)), 32'd22050,
                     prod * 32'd22050, prod[15:0], feed[15:0]);
            fmt_present = 1'b1;
        end
        if ($urandom_range(0, 99) < 95) begin
            push_fmt(fmt_size, fmt_code, ch, rate, brate, align, bits);
            fmt_present = 1'b1;
        end
        if ($urandom_range(0, 99) < 25) push_other_chunk();
        if ($urandom_range(0, 99) < 95) begin
            data_present = 1'b1;
            payload_inline = !fmt_present;
            case ($urandom_range(0, 19))
                0: dsize = $urandom;
                1: dsize = $urandom_range(0, 255);
                default: dsize = $urandom_range(0, 24);
            endcase
            if (payload_inline) dsize = $urandom_range(0, 8);
            push_le(TAG_DATA, 4);
            push_le(dsize, 4);
            if (payload_inline)
                for (int k = 0; k < dsize; k++)
                    file_bytes.push_back(8'($urandom_range(0, 255)));
        end

        riff_size = 32'd4 + file_bytes.size();
        if (data_present && !payload_inline) riff_size = riff_size + dsize;
        case ($urandom_range(0, 19))
            0: riff_size = $urandom_range(0, 3);
            1: riff_size = riff_size - $urandom_range(1, 12);
            2: riff_size = riff_size + $urandom_range(1, 12);
            default: ;
        endcase
        tail = file_bytes;
        file_bytes.delete();
        push_le(TAG_RIFF, 4);
        push_le(riff_size, 4);
        push_le(TAG_WAVE, 4);
        foreach (tail[k]) file_bytes.push_back(tail[k]);
        case ($urandom_range(0, 33))
            0: file_bytes[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
            1: file_bytes[$urandom_range(8, 11)] ^= 8'h01 << $urandom_range(0, 7);
            default: ;
        endcase

        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            eos_last = 1'b1;
        end else begin
            cut = file_bytes.size();
            eos_last = ($urandom_range(0, 2) == 0);
        end
        for (int k = 0; k < cut; k++)
            queue_word(MODE_HEADER, file_bytes[k], eos_last && (k == cut - 1));

        if (data_present && !payload_inline)
            feed = ((dsize < 40) ? dsize : 40) + $urandom_range(0, 5);
        else
            feed = $urandom_range(0, 3);
        for (int k = 0; k < feed; k++)
            queue_word(MODE_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) < 92)
            queue_word(MODE_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_noise();
        int unsigned n;
        n = $urandom_range(6, 16);
        for (int k = 0; k < n; k++)
            queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
    endtask

    function automatic bit words_differ(input result_t want, input result_t got);
        return got.kind !== want.kind || got.error_code !== want.error_code ||
               got.channel_count !== want.channel_count ||
               got.bits_per_sample !== want.bits_per_sample ||
               got.sample_rate !== want.sample_rate ||
               got.payload_offset !== want.payload_offset ||
               got.payload_size !== want.payload_size ||
               got.out_byte !== want.out_byte || got.frame_end !== want.frame_end;
    endfunction

    function automatic void report_word(input string what, input result_t want,
                                        input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("ERROR: %s (expected/actual) kind %0d/%0d err %0d/%0d ch %0d/%0d bits %0d/%0d",
                     what, want.kind, got.kind, want.error_code, got.error_code,
                     want.channel_count, got.channel_count,
                     want.bits_per_sample, got.bits_per_sample);
            $display("       rate %h/%h offset %h/%h size %h/%h byte %h/%h end %0d/%0d",
                     want.sample_rate, got.sample_rate, want.payload_offset,
                     got.payload_offset, want.payload_size, got.payload_size,
                     want.out_byte, got.out_byte, want.frame_end, got.frame_end);
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sender: bursts of words with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (!(cur_word.mode == MODE_UNUSED ||
                      (cur_word.mode == MODE_HEADER && hp_phase == PH_DONE)))
                    words_fed++;
                if (predict_word(cur_word.mode, cur_word.data, cur_word.eos) || cur_word.fixed)
                    expected_words.push_back(cur_word.fixed ? cur_word.want : pred_word);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= cur_word.mode;
                    s_in_byte <= cur_word.data;
                    s_end_of_stream <= cur_word.eos;
                    if (burst_left > 1) begin
                        burst_left = burst_left - 1;
                    end else if ($urandom_range(0, 6) == 0) begin
                        burst_left = $urandom_range(40, 150);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (ready_span == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            ready_span = $urandom_range(16, 160);
        end else begin
            ready_span = ready_span - 1;
        end
        ready_tick = ready_tick + 1;
        case (ready_style)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
            READY_PERIODIC: m_ready <= ((ready_tick % 7) < 4);
            default: m_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_error_code, m_channel_count, m_bits_per_sample, m_sample_rate,
                   m_payload_offset, m_payload_size, m_out_byte, m_frame_end};
            if (expected_words.size() == 0) begin
                report_word("result word with nothing expected", '0, got);
            end else begin
                want = expected_words.pop_front();
                if (words_differ(want, got)) report_word("result word differs", want, got);
            end
        end
    end

    initial begin
        stim_word_t w;
        parser_clear();
        for (int i = 0; i < 25; i++) begin
            w = '0;
            w.mode = DIRECTED_ROWS[i].mode;
            w.data = DIRECTED_ROWS[i].data;
            w.eos = DIRECTED_ROWS[i].eos;
            w.fixed = DIRECTED_ROWS[i].fixed;
            w.want.kind = DIRECTED_ROWS[i].kind;
            w.want.error_code = DIRECTED_ROWS[i].code;
            pending_words.push_back(w);
        end
        while (words_fed < WORD_TARGET) begin
            if (pending_words.size() < 32) begin
                if ($urandom_range(0, 99) < 8) queue_noise();
                else build_wav_file();
            end else begin
                @(posedge aclk);
            end
        end
        stim_done = 1'b1;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (!stim_done || pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== wav_header_parser_sample_unpack.f =====
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_parser.sv
hw/rtl/wavhp_out_stage.sv
hw/rtl/wav_header_parser_sample_unpack.sv
sim/testbench.sv
